// File: rtl/core/assert_macros.svh
// Assertion helpers for the checker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, idle in reset.
`define CHK_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, idle in reset.
`define CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/slrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package slrs_pkg;

	localparam int unsigned FIELD_BITS      = 24;
	localparam int unsigned NUM_RANGES_DEF  = 32;
	localparam int unsigned LINE_BITS_DEF   = 24;

	typedef enum logic {
		OP_ADD    = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	typedef struct packed {
		op_t                   operation;
		logic [FIELD_BITS-1:0] range_begin;
		logic [FIELD_BITS-1:0] range_end;
	} in_req_t;

	typedef struct packed {
		logic                  gap_valid;
		logic [FIELD_BITS-1:0] gap_begin;
		logic [FIELD_BITS-1:0] gap_end;
		logic                  last;
		logic                  overflow;
	} out_req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH,
		ST_FINAL
	} state_t;

	typedef enum logic [1:0] {
		PH_BEFORE,
		PH_MERGE,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic start;
		logic pop;
		logic live;
		logic flush;
		logic fin;
		logic full;
	} ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/sorted_line_range_set.sv
// Channel   Signals                        Moves
// request   req_valid, req_ready, req      operation and range, one per item
// result    rsp_valid, rsp_ready, rsp      gap reports, last marks the item's final one
//
// A non-empty item passes through accept, a pop of every table slot through the
// merge unit, a flush step and the final result.
// An empty or inverted range goes from accept straight to the final result.
// Reset empties the table at once. A held result (rsp_valid high, rsp_ready low)
// freezes the pass in place; req_ready is high only between items.
`timescale 1ns / 1ps
`default_nettype none

module sorted_line_range_set #(
	parameter int unsigned NUM_RANGES = slrs_pkg::NUM_RANGES_DEF,
	parameter int unsigned LINE_BITS  = slrs_pkg::LINE_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_ready,
	input  wire slrs_pkg::in_req_t  req,
	output logic                    rsp_valid,
	input  wire logic               rsp_ready,
	output slrs_pkg::out_req_t      rsp
);

	localparam int unsigned EW = 2 * LINE_BITS;
	localparam int unsigned KW = $clog2(NUM_RANGES);
	localparam int unsigned CW = $clog2(NUM_RANGES + 1);

	slrs_pkg::state_t     state_q;
	slrs_pkg::state_t     state_d;
	slrs_pkg::ctl_t       ctl;
	logic                 go;
	logic                 empty;
	logic [LINE_BITS-1:0] req_b;
	logic [LINE_BITS-1:0] req_e;
	logic [KW-1:0]        k_q;
	logic [CW-1:0]        cnt_q;
	logic [CW-1:0]        wcnt_q;
	logic                 sel_q;
	logic                 out_vld_q;
	slrs_pkg::out_req_t   out_q;
	logic                 push_vld;
	logic [EW-1:0]        push_ent;
	logic                 res_vld;
	slrs_pkg::out_req_t   res;
	logic [EW-1:0]        head;
	logic [EW-1:0]        a_val [NUM_RANGES];
	logic [EW-1:0]        b_val [NUM_RANGES];
	logic [EW-1:0]        a_in  [NUM_RANGES];
	logic [EW-1:0]        b_in  [NUM_RANGES];

	assign req_b = LINE_BITS'(req.range_begin);
	assign req_e = LINE_BITS'(req.range_end);
	assign empty = req_b >= req_e;
	assign go    = !out_vld_q || rsp_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			slrs_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_d = empty ? slrs_pkg::ST_FINAL : slrs_pkg::ST_SCAN;
				end
			end
			slrs_pkg::ST_SCAN: begin
				if (go && k_q == KW'(NUM_RANGES - 1)) begin
					state_d = slrs_pkg::ST_FLUSH;
				end
			end
			slrs_pkg::ST_FLUSH: begin
				if (go) begin
					state_d = slrs_pkg::ST_FINAL;
				end
			end
			slrs_pkg::ST_FINAL: begin
				if (go) begin
					state_d = slrs_pkg::ST_IDLE;
				end
			end
			default: state_d = slrs_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready = state_q == slrs_pkg::ST_IDLE;
		ctl.start = req_valid && state_q == slrs_pkg::ST_IDLE;
		ctl.pop   = go && state_q == slrs_pkg::ST_SCAN;
		ctl.live  = CW'(k_q) >= (CW'(NUM_RANGES) - cnt_q);
		ctl.flush = go && state_q == slrs_pkg::ST_FLUSH;
		ctl.fin   = go && state_q == slrs_pkg::ST_FINAL;
		ctl.full  = cnt_q == CW'(NUM_RANGES);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= slrs_pkg::ST_IDLE;
			k_q       <= '0;
			cnt_q     <= '0;
			wcnt_q    <= '0;
			sel_q     <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.start) begin
				k_q    <= '0;
				wcnt_q <= '0;
			end else if (ctl.pop) begin
				k_q <= k_q + KW'(1);
				if (push_vld) begin
					wcnt_q <= wcnt_q + CW'(1);
				end
			end
			if (ctl.flush) begin
				cnt_q <= wcnt_q + CW'(push_vld);
				sel_q <= ~sel_q;
			end
			if (go) begin
				out_vld_q <= res_vld;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			out_q <= res;
		end
	end

	assign rsp_valid = out_vld_q;
	assign rsp       = out_q;

	assign head = sel_q ? b_val[0] : a_val[0];

	for (genvar i = 0; i < NUM_RANGES; i++) begin : g_cell
		if (i == NUM_RANGES - 1) begin : g_tail
			assign a_in[i] = push_ent;
			assign b_in[i] = push_ent;
		end else begin : g_mid
			assign a_in[i] = a_val[i+1];
			assign b_in[i] = b_val[i+1];
		end
		slrs_cell #(
			.ENT_BITS(EW)
		) u_cell (
			.clk  (clk),
			.sel  (sel_q),
			.rd_en(ctl.pop),
			.wr_en(push_vld),
			.a_in (a_in[i]),
			.b_in (b_in[i]),
			.a_out(a_val[i]),
			.b_out(b_val[i])
		);
	end

	slrs_merge #(
		.LINE_BITS(LINE_BITS)
	) u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.op_in   (req.operation),
		.b_in    (req_b),
		.e_in    (req_e),
		.head    (head),
		.push_vld(push_vld),
		.push_ent(push_ent),
		.res_vld (res_vld),
		.res     (res)
	);

endmodule

`default_nettype wire

// File: rtl/core/slrs_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One table slot in each of two banks; the banks swap read/write roles per pass.
module slrs_cell #(
	parameter int unsigned ENT_BITS = 2 * slrs_pkg::LINE_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                sel,
	input  wire logic                rd_en,
	input  wire logic                wr_en,
	input  wire logic [ENT_BITS-1:0] a_in,
	input  wire logic [ENT_BITS-1:0] b_in,
	output logic      [ENT_BITS-1:0] a_out,
	output logic      [ENT_BITS-1:0] b_out
);

	logic [ENT_BITS-1:0] a_q;
	logic [ENT_BITS-1:0] b_q;
	logic                a_en;
	logic                b_en;

	assign a_en = sel ? wr_en : rd_en;
	assign b_en = sel ? rd_en : wr_en;

	always_ff @(posedge clk) begin
		if (a_en) begin
			a_q <= a_in;
		end
		if (b_en) begin
			b_q <= b_in;
		end
	end

	assign a_out = a_q;
	assign b_out = b_q;

endmodule

`default_nettype wire

// File: rtl/core/slrs_merge.sv
`timescale 1ns / 1ps
`default_nettype none

// Streaming merge: takes table entries in order, pushes the updated table and reports gaps.
module slrs_merge #(
	parameter int unsigned LINE_BITS = slrs_pkg::LINE_BITS_DEF,
	localparam int unsigned EW = 2 * LINE_BITS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire slrs_pkg::ctl_t       ctl,
	input  wire slrs_pkg::op_t        op_in,
	input  wire logic [LINE_BITS-1:0] b_in,
	input  wire logic [LINE_BITS-1:0] e_in,
	input  wire logic [EW-1:0]        head,
	output logic                      push_vld,
	output logic      [EW-1:0]        push_ent,
	output logic                      res_vld,
	output slrs_pkg::out_req_t        res
);

	slrs_pkg::op_t        op_q;
	logic [LINE_BITS-1:0] b_q;
	logic [LINE_BITS-1:0] e_q;
	slrs_pkg::phase_t     phase_q;
	slrs_pkg::phase_t     phase_d;
	logic [LINE_BITS-1:0] acc_lo_q;
	logic [LINE_BITS-1:0] acc_lo_d;
	logic [LINE_BITS-1:0] acc_hi_q;
	logic [LINE_BITS-1:0] acc_hi_d;
	logic [LINE_BITS-1:0] pos_q;
	logic [LINE_BITS-1:0] pos_d;
	logic                 ovf_q;
	logic                 ovf_d;
	logic                 hold_vld_q;
	logic                 hold_vld_d;
	logic [EW-1:0]        hold_q;
	logic [EW-1:0]        hold_d;
	logic                 pend_vld_q;
	logic [LINE_BITS-1:0] pend_b_q;
	logic [LINE_BITS-1:0] pend_e_q;

	logic                 adv;
	logic [LINE_BITS-1:0] s_lo;
	logic [LINE_BITS-1:0] s_hi;
	logic                 em0_vld;
	logic [EW-1:0]        em0;
	logic                 em1_vld;
	logic [EW-1:0]        em1;
	logic                 gap_vld;
	logic [LINE_BITS-1:0] gap_b;
	logic [LINE_BITS-1:0] gap_e;

	assign adv  = ctl.pop | ctl.flush;
	assign s_lo = head[EW-1:LINE_BITS];
	assign s_hi = head[LINE_BITS-1:0];

	always_comb begin
		em0_vld  = 1'b0;
		em0      = '0;
		em1_vld  = 1'b0;
		em1      = '0;
		gap_vld  = 1'b0;
		gap_b    = '0;
		gap_e    = '0;
		phase_d  = phase_q;
		acc_lo_d = acc_lo_q;
		acc_hi_d = acc_hi_q;
		pos_d    = pos_q;
		ovf_d    = ovf_q;
		if (ctl.pop && ctl.live) begin
			if (op_q == slrs_pkg::OP_ADD) begin
				unique case (phase_q)
					slrs_pkg::PH_BEFORE: begin
						if (s_hi < b_q) begin
							em0_vld = 1'b1;
							em0     = head;
						end else if (s_lo > e_q) begin
							phase_d = slrs_pkg::PH_DONE;
							if (ctl.full) begin
								ovf_d   = 1'b1;
								em0_vld = 1'b1;
								em0     = head;
							end else begin
								em0_vld = 1'b1;
								em0     = {b_q, e_q};
								em1_vld = 1'b1;
								em1     = head;
								gap_vld = 1'b1;
								gap_b   = b_q;
								gap_e   = e_q;
							end
						end else begin
							acc_lo_d = (s_lo < b_q) ? s_lo : b_q;
							acc_hi_d = (s_hi > e_q) ? s_hi : e_q;
							gap_vld  = b_q < s_lo;
							gap_b    = b_q;
							gap_e    = s_lo;
							pos_d    = s_hi;
							phase_d  = slrs_pkg::PH_MERGE;
						end
					end
					slrs_pkg::PH_MERGE: begin
						if (s_lo <= e_q) begin
							acc_hi_d = (s_hi > acc_hi_q) ? s_hi : acc_hi_q;
							gap_vld  = pos_q < s_lo;
							gap_b    = pos_q;
							gap_e    = s_lo;
							pos_d    = s_hi;
						end else begin
							gap_vld = pos_q < e_q;
							gap_b   = pos_q;
							gap_e   = e_q;
							em0_vld = 1'b1;
							em0     = {acc_lo_q, acc_hi_q};
							em1_vld = 1'b1;
							em1     = head;
							phase_d = slrs_pkg::PH_DONE;
						end
					end
					default: begin
						em0_vld = 1'b1;
						em0     = head;
					end
				endcase
			end else begin
				if (phase_q == slrs_pkg::PH_DONE || s_lo >= e_q || s_hi <= b_q) begin
					em0_vld = 1'b1;
					em0     = head;
				end else if (s_lo < b_q && e_q < s_hi) begin
					if (ctl.full) begin
						ovf_d   = 1'b1;
						phase_d = slrs_pkg::PH_DONE;
						em0_vld = 1'b1;
						em0     = head;
					end else begin
						em0_vld = 1'b1;
						em0     = {s_lo, b_q};
						em1_vld = 1'b1;
						em1     = {e_q, s_hi};
					end
				end else if (s_lo < b_q) begin
					em0_vld = 1'b1;
					em0     = {s_lo, b_q};
				end else if (s_hi > e_q) begin
					em0_vld = 1'b1;
					em0     = {e_q, s_hi};
				end
			end
		end else if (ctl.flush && op_q == slrs_pkg::OP_ADD) begin
			if (phase_q == slrs_pkg::PH_BEFORE) begin
				if (ctl.full) begin
					ovf_d = 1'b1;
				end else begin
					em0_vld = 1'b1;
					em0     = {b_q, e_q};
					gap_vld = 1'b1;
					gap_b   = b_q;
					gap_e   = e_q;
				end
			end else if (phase_q == slrs_pkg::PH_MERGE) begin
				gap_vld = pos_q < e_q;
				gap_b   = pos_q;
				gap_e   = e_q;
				em0_vld = 1'b1;
				em0     = {acc_lo_q, acc_hi_q};
			end
			phase_d = slrs_pkg::PH_DONE;
		end
	end

	// one-deep hold absorbs the single extra entry an insert or split makes
	always_comb begin
		push_vld   = 1'b0;
		push_ent   = hold_q;
		hold_vld_d = hold_vld_q;
		hold_d     = hold_q;
		if (adv) begin
			if (hold_vld_q) begin
				push_vld   = 1'b1;
				push_ent   = hold_q;
				hold_vld_d = em0_vld;
				hold_d     = em0;
			end else begin
				push_vld   = em0_vld;
				push_ent   = em0;
				hold_vld_d = em1_vld;
				hold_d     = em1;
			end
		end
	end

	always_comb begin
		res_vld = 1'b0;
		res     = '0;
		if (ctl.fin) begin
			res_vld  = 1'b1;
			res.last = 1'b1;
			if (pend_vld_q) begin
				res.gap_valid = 1'b1;
				res.gap_begin = slrs_pkg::FIELD_BITS'(pend_b_q);
				res.gap_end   = slrs_pkg::FIELD_BITS'(pend_e_q);
			end else begin
				res.overflow = ovf_q;
			end
		end else if (adv && gap_vld && pend_vld_q) begin
			res_vld       = 1'b1;
			res.gap_valid = 1'b1;
			res.gap_begin = slrs_pkg::FIELD_BITS'(pend_b_q);
			res.gap_end   = slrs_pkg::FIELD_BITS'(pend_e_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= slrs_pkg::PH_BEFORE;
			ovf_q      <= 1'b0;
			hold_vld_q <= 1'b0;
			pend_vld_q <= 1'b0;
		end else if (ctl.start) begin
			phase_q    <= slrs_pkg::PH_BEFORE;
			ovf_q      <= 1'b0;
			hold_vld_q <= 1'b0;
			pend_vld_q <= 1'b0;
		end else if (adv) begin
			phase_q    <= phase_d;
			ovf_q      <= ovf_d;
			hold_vld_q <= hold_vld_d;
			if (gap_vld) begin
				pend_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			op_q <= op_in;
			b_q  <= b_in;
			e_q  <= e_in;
		end
		if (adv) begin
			acc_lo_q <= acc_lo_d;
			acc_hi_q <= acc_hi_d;
			pos_q    <= pos_d;
			hold_q   <= hold_d;
			if (gap_vld) begin
				pend_b_q <= gap_b;
				pend_e_q <= gap_e;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/slrs_chk.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module slrs_chk (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               req_valid,
	input wire logic               req_ready,
	input wire logic               rsp_valid,
	input wire logic               rsp_ready,
	input wire slrs_pkg::out_req_t rsp
);

	`CHK_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "rsp changed while stalled")
	`CHK_IMPLY(a_empty_zero, rsp_valid && !rsp.gap_valid, rsp.gap_begin == 0 && rsp.gap_end == 0, "empty result carries a range")
	`CHK_IMPLY(a_ovf_alone, rsp_valid && rsp.overflow, rsp.last && !rsp.gap_valid, "overflow result not a lone final")
	`CHK_IMPLY(a_gap_order, rsp_valid && rsp.gap_valid, rsp.gap_begin < rsp.gap_end, "gap is empty")
	`CHK_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "second request taken mid item")

endmodule

bind sorted_line_range_set slrs_chk u_slrs_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_ready(req_ready),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp      (rsp)
);

`default_nettype wire
